// ----- rtl/core/zob_pkg.sv -----
package zob_pkg;

  localparam int ZOB_CODE_W      = 64;
  localparam int ZOB_COORD_BITS  = 32;

  // case codes at one bit position: {probe, low corner, high corner}
  localparam logic [2:0] SEL_EQ_ZERO   = 3'b000;
  localparam logic [2:0] SEL_BIG_SPLIT = 3'b001;
  localparam logic [2:0] SEL_ERR_LO    = 3'b010;
  localparam logic [2:0] SEL_BIG_HIT   = 3'b011;
  localparam logic [2:0] SEL_LIT_HIT   = 3'b100;
  localparam logic [2:0] SEL_LIT_SPLIT = 3'b101;
  localparam logic [2:0] SEL_ERR_HI    = 3'b110;
  localparam logic [2:0] SEL_EQ_ONE    = 3'b111;

  typedef struct packed {
    logic [ZOB_CODE_W-1:0] probe_code;
    logic [ZOB_CODE_W-1:0] box_low_code;
    logic [ZOB_CODE_W-1:0] box_high_code;
  } zob_in_t;

  typedef struct packed {
    logic [ZOB_CODE_W-1:0] litmax_code;
    logic [ZOB_CODE_W-1:0] bigmin_code;
    logic                  order_error;
  } zob_out_t;

endpackage

// ----- rtl/core/zob_load_unit.sv -----
module zob_load_unit import zob_pkg::*; #(
  parameter int CODE_BITS = 2 * ZOB_COORD_BITS,
  parameter int POS_W     = $clog2(CODE_BITS)
) (
  input  logic [POS_W-1:0]     pos,
  input  logic [CODE_BITS-1:0] lo,
  input  logic [CODE_BITS-1:0] hi,
  output logic [CODE_BITS-1:0] lo_up,
  output logic [CODE_BITS-1:0] hi_down
);

  localparam logic [CODE_BITS-1:0] LANE_X  = {(CODE_BITS / 2){2'b01}};
  localparam logic [CODE_BITS-1:0] ALL_ONE = {CODE_BITS{1'b1}};
  localparam logic [POS_W-1:0]     POS_TOP = POS_W'(CODE_BITS - 1);

  logic [CODE_BITS-1:0] lane;
  logic [CODE_BITS-1:0] below;
  logic [CODE_BITS-1:0] lane_mask;
  logic [CODE_BITS-1:0] pos_bit;

  // bits of the current dimension at or below pos
  assign lane      = LANE_X << pos[0];
  assign below     = ALL_ONE >> (POS_TOP - pos);
  assign lane_mask = lane & below;
  assign pos_bit   = CODE_BITS'(1) << pos;

  // "1000.." into the low corner, "0111.." into the high corner
  assign lo_up   = (lo & ~lane_mask) | pos_bit;
  assign hi_down = (hi & ~lane_mask) | (lane_mask & ~pos_bit);

endmodule

// ----- rtl/core/z_order_bigmin_litmax_top.sv -----
// channel | beat type  | handshake
// in      | zob_in_t   | in_valid / in_stall
// out     | zob_out_t  | out_valid / out_stall
//
// after acceptance an item is scanned one bit position a cycle through the shared load unit,
// from the top bit down until an ending case or bit 0; the result then moves into the output
// register once that register is free
// in_stall is high from acceptance until the result is written to the output register
// out_stall holds the finished beat in the output register; the next item is taken meanwhile
// rst is synchronous and clears the sequencer and out_valid
module z_order_bigmin_litmax_top import zob_pkg::*; #(
  parameter int COORD_BITS = ZOB_COORD_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  zob_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output zob_out_t out_data
);

  localparam int CODE_BITS = 2 * COORD_BITS;
  localparam int POS_W     = $clog2(CODE_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t               state;
  logic [POS_W-1:0]     pos;
  logic [CODE_BITS-1:0] probe;
  logic [CODE_BITS-1:0] lo;
  logic [CODE_BITS-1:0] hi;
  logic [CODE_BITS-1:0] litmax;
  logic [CODE_BITS-1:0] bigmin;
  logic                 err;

  logic [CODE_BITS-1:0] lo_next;
  logic [CODE_BITS-1:0] hi_next;
  logic [CODE_BITS-1:0] litmax_next;
  logic [CODE_BITS-1:0] bigmin_next;
  logic                 err_next;
  logic                 stop;
  logic [2:0]           sel;
  logic [CODE_BITS-1:0] lo_up;
  logic [CODE_BITS-1:0] hi_down;

  zob_load_unit #(
    .CODE_BITS(CODE_BITS),
    .POS_W    (POS_W)
  ) u_load (
    .pos    (pos),
    .lo     (lo),
    .hi     (hi),
    .lo_up  (lo_up),
    .hi_down(hi_down)
  );

  assign sel = {probe[pos], lo[pos], hi[pos]};

  always_comb begin
    lo_next     = lo;
    hi_next     = hi;
    litmax_next = litmax;
    bigmin_next = bigmin;
    err_next    = err;
    stop        = 1'b0;
    case (sel)
      SEL_BIG_SPLIT: begin
        bigmin_next = lo_up;
        hi_next     = hi_down;
      end
      SEL_BIG_HIT: begin
        bigmin_next = lo;
        stop        = 1'b1;
      end
      SEL_LIT_HIT: begin
        litmax_next = hi;
        stop        = 1'b1;
      end
      SEL_LIT_SPLIT: begin
        litmax_next = hi_down;
        lo_next     = lo_up;
      end
      SEL_ERR_LO, SEL_ERR_HI: begin
        err_next = 1'b1;
        stop     = 1'b1;
      end
      SEL_EQ_ZERO, SEL_EQ_ONE: begin
      end
      default: begin
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // the flush state sets out_valid itself when it moves a beat in
      if (out_valid && !out_stall && state != S_FLUSH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            probe  <= in_data.probe_code[CODE_BITS-1:0];
            lo     <= in_data.box_low_code[CODE_BITS-1:0];
            hi     <= in_data.box_high_code[CODE_BITS-1:0];
            litmax <= '0;
            bigmin <= '0;
            err    <= 1'b0;
            pos    <= POS_W'(CODE_BITS - 1);
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          lo     <= lo_next;
          hi     <= hi_next;
          litmax <= litmax_next;
          bigmin <= bigmin_next;
          err    <= err_next;
          if (stop || pos == '0) begin
            state <= S_FLUSH;
          end else begin
            pos <= pos - 1'b1;
          end
        end
        S_FLUSH: begin
          // wait for the output register to free up
          if (!out_valid || !out_stall) begin
            out_data.litmax_code <= ZOB_CODE_W'(litmax);
            out_data.bigmin_code <= ZOB_CODE_W'(bigmin);
            out_data.order_error <= err;
            out_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
